// ===== src/u128_divide_remainder_assert.svh =====
// Assertion macros shared by the 128-bit divider modules.
`ifndef U128_DIVIDE_REMAINDER_ASSERT_SVH
`define U128_DIVIDE_REMAINDER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clock and disabled during reset.
`define U128DR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock and disabled during reset.
`define U128DR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define U128DR_ASSERT_IMP(lbl, ante, cons, msg)
`define U128DR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/u128dr_pkg.sv =====
// Types and constants of the 128-bit divider.
`timescale 1ns / 1ps
package u128dr_pkg;

   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned DATA_BITS  = 2 * WORD_BITS;
   // One quotient bit is resolved per pipeline stage.
   localparam int unsigned NUM_STAGES = DATA_BITS;

   // Work carried by one pipeline stage. The upper half of rem_quo is the
   // partial remainder; the lower half starts as the dividend and fills up
   // with quotient bits from the right as dividend bits leave on the left.
   typedef struct packed {
      logic [2*DATA_BITS-1:0] rem_quo;
      logic [DATA_BITS-1:0]   divisor;
      logic                   divide_by_zero;
   } u128dr_item_type;

   // Flow control handed from the top level to the pipeline.
   typedef struct packed {
      logic in_valid;
      logic advance;
   } u128dr_ctrl_type;

endpackage

// ===== src/u128dr_stage.sv =====
// One restoring-division step followed by its pipeline register.
`timescale 1ns / 1ps
module u128dr_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  u128dr_pkg::u128dr_item_type in_item,
   output logic                      out_valid,
   output u128dr_pkg::u128dr_item_type out_item
);
   import u128dr_pkg::*;

   logic [DATA_BITS:0]   partial;
   logic [DATA_BITS:0]   diff;
   logic                 take;
   u128dr_item_type      item_in;
   u128dr_item_type      item_ff;
   logic                 valid_ff;
   logic                 valid_in;

   // The shifted partial remainder is 129 bits wide; its top bit is the
   // bit that would be lost in a 128-bit register.
   assign partial = in_item.rem_quo[2*DATA_BITS-1:DATA_BITS-1];
   assign diff    = partial - {1'b0, in_item.divisor};
   assign take    = ~diff[DATA_BITS];

   always_comb begin
      item_in                = in_item;
      item_in.rem_quo        = {(take ? diff[DATA_BITS-1:0] : partial[DATA_BITS-1:0]),
                                in_item.rem_quo[DATA_BITS-2:0], take};
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/u128dr_pipe.sv =====
// Chain of division stages, one quotient bit per stage.
`timescale 1ns / 1ps
module u128dr_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  u128dr_pkg::u128dr_ctrl_type ctrl,
   input  u128dr_pkg::u128dr_item_type in_item,
   output logic                        out_valid,
   output u128dr_pkg::u128dr_item_type out_item
);
   import u128dr_pkg::*;
   `include "u128_divide_remainder_assert.svh"

   logic [NUM_STAGES:0] valid_chain;
   u128dr_item_type     item_chain [NUM_STAGES+1];

   assign valid_chain[0] = ctrl.in_valid;
   assign item_chain[0]  = in_item;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      u128dr_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (ctrl.advance),
         .in_valid (valid_chain[g]),
         .in_item  (item_chain[g]),
         .out_valid(valid_chain[g+1]),
         .out_item (item_chain[g+1])
      );
   end

   assign out_valid = valid_chain[NUM_STAGES];
   assign out_item  = item_chain[NUM_STAGES];

   // A finished division by a nonzero divisor leaves a remainder below it.
   `U128DR_ASSERT_IMP(a_rem_below_divisor, out_valid && !out_item.divide_by_zero, out_item.rem_quo[2*DATA_BITS-1:DATA_BITS] < out_item.divisor, "remainder not below divisor")
   // An accepted beat shows up in the first stage in the next cycle.
   `U128DR_ASSERT_NXT(a_enter_first, ctrl.in_valid && ctrl.advance, valid_chain[1], "accepted beat lost at entry")
   // A stalled pipeline holds its occupancy pattern.
   `U128DR_ASSERT_NXT(a_stall_holds, !ctrl.advance, $stable(valid_chain[NUM_STAGES:1]), "stage valid changed during stall")

endmodule

// ===== src/u128_divide_remainder.sv =====
// Top level of the pipelined 128-bit unsigned divider with remainder.
`timescale 1ns / 1ps
// This block divides a 128-bit unsigned dividend by a 128-bit unsigned
// divisor and returns the floor quotient and the remainder, each split into
// 64-bit halves. It is a restoring divider unrolled into 128 register
// stages, each of which resolves one quotient bit with a single 129-bit
// subtract, followed by one output register. A new beat can be accepted on
// every clock cycle while the pipeline does not stall, so the sustained rate
// is one division per cycle; an accepted beat passes through the 128 step
// stages and then the output register to the rsp_ side. The whole pipeline
// moves together: it stalls only when the output register holds a result
// that has not been taken and the last stage also holds a finished division.
// An empty last stage never stalls the pipeline, so gaps in the stream close
// up at its far end, but during a stall every stage holds, empty ones
// included. A zero divisor gives an all-ones quotient, the dividend as
// remainder, and raises rsp_divide_by_zero; this falls out of the same
// datapath, since every subtraction of zero succeeds. There is no
// configuration and no state beyond the divisions in flight.
module u128_divide_remainder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_dividend_low,
   input  logic [63:0] req_dividend_high,
   input  logic [63:0] req_divisor_low,
   input  logic [63:0] req_divisor_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_quotient_low,
   output logic [63:0] rsp_quotient_high,
   output logic [63:0] rsp_remainder_low,
   output logic [63:0] rsp_remainder_high,
   output logic        rsp_divide_by_zero
);
   import u128dr_pkg::*;
   `include "u128_divide_remainder_assert.svh"

   u128dr_ctrl_type       ctrl;
   u128dr_item_type       in_item;
   u128dr_item_type       last_item;
   logic                  last_valid;
   logic                  advance;
   logic                  load_out;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_BITS-1:0]  quotient_ff;
   logic [DATA_BITS-1:0]  remainder_ff;
   logic                  zero_ff;

   // The pipeline moves unless its last stage holds a finished beat that
   // cannot move into an occupied, unread output register.
   assign advance   = !last_valid || !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign load_out  = last_valid && advance;

   assign ctrl.in_valid = req_valid;
   assign ctrl.advance  = advance;

   // The partial remainder starts at zero and the dividend sits in the
   // low half, ready to be shifted in one bit per stage.
   always_comb begin
      in_item.rem_quo        = {{DATA_BITS{1'b0}}, req_dividend_high, req_dividend_low};
      in_item.divisor        = {req_divisor_high, req_divisor_low};
      in_item.divide_by_zero = (req_divisor_high == '0) && (req_divisor_low == '0);
   end

   u128dr_pipe u_pipe (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .in_item  (in_item),
      .out_valid(last_valid),
      .out_item (last_item)
   );

   // Output register: filled from the last stage, emptied when taken.
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         remainder_ff <= last_item.rem_quo[2*DATA_BITS-1:DATA_BITS];
         quotient_ff  <= last_item.rem_quo[DATA_BITS-1:0];
         zero_ff      <= last_item.divide_by_zero;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient_low   = quotient_ff[WORD_BITS-1:0];
   assign rsp_quotient_high  = quotient_ff[DATA_BITS-1:WORD_BITS];
   assign rsp_remainder_low  = remainder_ff[WORD_BITS-1:0];
   assign rsp_remainder_high = remainder_ff[DATA_BITS-1:WORD_BITS];
   assign rsp_divide_by_zero = zero_ff;

   // A zero divisor must come out with an all-ones quotient.
   `U128DR_ASSERT_IMP(a_zero_all_ones, rsp_valid && rsp_divide_by_zero, (rsp_quotient_high == '1) && (rsp_quotient_low == '1), "zero divisor quotient not all ones")

endmodule
